// ----- src/cpiop_pkg.sv -----
// Shared types, constants and header layout functions of the cpio stream parser.
package cpiop_pkg;

	localparam int LENGTH_BITS = 33;
	localparam int VALUE_W = 33;
	localparam logic [2:0] FORMAT_RESET = 3'd3;
	localparam logic [2:0] FMT_BIN_LE = 3'd0;
	localparam logic [2:0] FMT_BIN_BE = 3'd1;
	localparam logic [2:0] FMT_HEX = 3'd3;
	localparam logic [1:0] LAY_BIN = 2'd0;
	localparam logic [1:0] LAY_OCT = 2'd1;
	localparam logic [1:0] LAY_HEX = 2'd2;
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_HEADER = 3'd1;
	localparam logic [2:0] ERR_NAME = 3'd2;
	localparam logic [2:0] ERR_NAMEPAD = 3'd3;
	localparam logic [2:0] ERR_CONTENTS = 3'd4;
	localparam logic [2:0] ERR_CONTPAD = 3'd5;
	localparam logic [2:0] FT_INVALID = 3'd7;
	localparam logic [0:0] REG_FORMAT = 1'b0;

	typedef enum logic [2:0] {
		SEG_HEADER = 3'd0,
		SEG_NAME = 3'd1,
		SEG_NAMEPAD = 3'd2,
		SEG_CONTENTS = 3'd3,
		SEG_CONTPAD = 3'd4,
		SEG_ARCHIVE = 3'd5
	} seg_t;

	typedef struct packed {
		logic [2:0] fmt;
		logic       restart;
	} cfg_t;

	function automatic logic [1:0] layout(input logic [2:0] fmt);
		if (fmt <= FMT_BIN_BE) return LAY_BIN;
		if (fmt == 3'd2) return LAY_OCT;
		return LAY_HEX;
	endfunction

	function automatic logic [3:0] field_len(input logic [1:0] lay, input logic [3:0] idx);
		logic [3:0] r;
		r = 4'd0;
		case (lay)
			LAY_BIN: if (idx <= 4'd10) r = (idx == 4'd8 || idx == 4'd10) ? 4'd4 : 4'd2;
			LAY_OCT: if (idx <= 4'd10) r = (idx == 4'd8 || idx == 4'd10) ? 4'd11 : 4'd6;
			default: r = (idx == 4'd0) ? 4'd6 : 4'd8;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] field_count(input logic [1:0] lay);
		return (lay == LAY_HEX) ? 4'd14 : 4'd11;
	endfunction

	function automatic logic [6:0] header_size(input logic [1:0] lay);
		case (lay)
			LAY_BIN: return 7'd26;
			LAY_OCT: return 7'd76;
			default: return 7'd110;
		endcase
	endfunction

	function automatic logic quiet_field(input logic [1:0] lay, input logic [3:0] idx);
		logic [15:0] m;
		m = (lay == LAY_HEX) ? 16'h2C01 : 16'h0081;
		return m[idx];
	endfunction

	function automatic logic [3:0] mode_field(input logic [1:0] lay);
		return (lay == LAY_HEX) ? 4'd2 : 4'd3;
	endfunction

	function automatic logic [3:0] namesize_field(input logic [1:0] lay);
		return (lay == LAY_HEX) ? 4'd12 : 4'd9;
	endfunction

	function automatic logic [3:0] filesize_field(input logic [1:0] lay);
		return (lay == LAY_HEX) ? 4'd7 : 4'd10;
	endfunction

	// Expected byte of the trailer header at a given header position.
	function automatic logic [7:0] trailer_byte(input logic [2:0] fmt, input logic [6:0] pos);
		logic [7:0] r;
		r = 8'h00;
		case (fmt)
			FMT_BIN_LE: begin
				if (pos == 7'd0) r = 8'hC7;
				else if (pos == 7'd1) r = 8'h71;
				else if (pos == 7'd12) r = 8'h01;
				else if (pos == 7'd20) r = 8'h0B;
			end
			FMT_BIN_BE: begin
				if (pos == 7'd0) r = 8'h71;
				else if (pos == 7'd1) r = 8'hC7;
				else if (pos == 7'd13) r = 8'h01;
				else if (pos == 7'd21) r = 8'h0B;
			end
			3'd2: begin
				if (pos < 7'd6) r = pos[0] ? "7" : "0";
				else if (pos == 7'd41 || pos == 7'd63) r = "1";
				else if (pos == 7'd64) r = "3";
				else r = "0";
			end
			default: begin
				if (pos < 7'd5) r = pos[0] ? "7" : "0";
				else if (pos == 7'd5) r = (fmt == FMT_HEX) ? "1" : "2";
				else if (pos == 7'd45) r = "1";
				else if (pos == 7'd101) r = "B";
				else r = "0";
			end
		endcase
		return r;
	endfunction

	// Returns {valid, digit}.
	function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
		logic [4:0] r;
		r = 5'd0;
		if (b >= "0" && b <= "7") r = {1'b1, 4'(b - "0")};
		else if (b == "8" || b == "9") r = {hex, 4'(b - "0")};
		else if (hex && b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
		else if (hex && b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
		return r;
	endfunction

	function automatic logic [2:0] file_type_of(input logic [VALUE_W-1:0] mode);
		logic [2:0] r;
		r = FT_INVALID;
		if (mode[VALUE_W-1:16] == '0) begin
			case (mode[15:12])
				4'd1: r = 3'd0;
				4'd2: r = 3'd1;
				4'd4: r = 3'd2;
				4'd6: r = 3'd3;
				4'd8: r = 3'd4;
				4'd10: r = 3'd5;
				4'd12: r = 3'd6;
				default: r = FT_INVALID;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- src/cpiop_apb.sv -----
// Configuration register port holding the archive format.
module cpiop_apb (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cpiop_pkg::cfg_t  cfg
);
	logic [2:0] fmt_q;
	logic       wr_fmt;

	assign pready = 1'b1;
	assign wr_fmt = psel && penable && pwrite && (paddr[2] == cpiop_pkg::REG_FORMAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= cpiop_pkg::FORMAT_RESET;
		end else if (wr_fmt) begin
			fmt_q <= pwdata[2:0];
		end
	end

	assign prdata = (paddr[2] == cpiop_pkg::REG_FORMAT) ? {29'd0, fmt_q} : 32'd0;
	assign cfg.fmt = fmt_q;
	// Any write of the format register restarts parsing at a fresh header.
	assign cfg.restart = wr_fmt;
endmodule

// ----- src/cpio_archive_stream_parser_unit.sv -----
// Top level of the cpio archive stream parser.
// Archive bytes enter on the s_ channel, one byte per request, with s_tlast on the
// final byte of the archive. Every byte yields one result on the m_ channel: its
// region in m_tuser, and in m_tdata the header field index, a field-done flag,
// the decoded field value, the file type, a trailer flag and a truncation error.
// The archive format is set through the APB port; a write restarts parsing.
// The result is registered: a byte accepted at one edge has its result valid after
// that edge. Throughput is one byte per cycle unless the receiver stalls, set by
// the single pass of header counter, digit accumulate and trailer compare logic
// feeding the result register. s_tready stays high while the result register is
// empty or being taken; when the receiver stalls, the result is held and further
// bytes are refused until it is taken. Reset empties the result register and
// returns to the start of a header with the hex ASCII format selected.
module cpio_archive_stream_parser_unit #(
	parameter int LENGTH_BITS = cpiop_pkg::LENGTH_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// field_index[3:0], field_done[4], field_value[37:5], file_type[40:38],
	// trailer_found[41], error_code[44:42], zero[47:45]
	output logic [47:0] m_tdata,
	output logic [2:0]  m_tuser,   // region[2:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int VW = cpiop_pkg::VALUE_W;
	typedef logic [LENGTH_BITS-1:0] len_t;

	cpiop_pkg::cfg_t cfg;

	cpiop_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	cpiop_pkg::seg_t seg_q, seg_n;
	logic [6:0]    pos_q, pos_n;
	logic [3:0]    fidx_q, fidx_n, foff_q, foff_n;
	logic [VW-1:0] acc_q, acc_n;
	logic          nul_q, nul_n, stop_q, stop_n, tm_q, tm_n;
	len_t          nl_q, nl_n, cl_q, cl_n, br_q, br_n;

	logic          take;
	logic [1:0]    lay;
	logic [3:0]    fl;
	logic [2:0]    err;
	logic [2:0]    ft;
	logic          done, trl;
	logic [VW-1:0] val, v, acc_base;
	logic [4:0]    dig, sh;
	logic [6:0]    pos_inc;
	len_t          br_dec;

	// Next non-empty segment after s; an empty name or contents is skipped with its padding.
	function automatic void next_seg(input cpiop_pkg::seg_t s, input logic [1:0] ly,
			input len_t nl, input len_t cl, output cpiop_pkg::seg_t ns, output len_t rem);
		len_t   lens [1:4];
		logic   found;
		lens[1] = nl;
		lens[2] = (nl == '0 || ly == cpiop_pkg::LAY_OCT) ? len_t'(0) :
			(ly == cpiop_pkg::LAY_BIN) ? len_t'(nl[0]) :
			len_t'(2'(2'd0 - (nl[1:0] + 2'd2)));
		lens[3] = cl;
		lens[4] = (ly == cpiop_pkg::LAY_OCT) ? len_t'(0) :
			(ly == cpiop_pkg::LAY_BIN) ? len_t'(cl[0]) : len_t'(2'(2'd0 - cl[1:0]));
		found = 1'b0;
		ns = cpiop_pkg::SEG_HEADER;
		rem = '0;
		for (int j = 1; j <= 4; j++) begin
			if (!found && 3'(j) > s && lens[j] != '0) begin
				found = 1'b1;
				ns = cpiop_pkg::seg_t'(3'(j));
				rem = lens[j];
			end
		end
	endfunction

	assign s_tready = !m_tvalid || m_tready;
	assign take = s_tvalid && s_tready;
	assign lay = cpiop_pkg::layout(cfg.fmt);
	assign fl = cpiop_pkg::field_len(lay, fidx_q);

	always_comb begin
		seg_n = seg_q; pos_n = pos_q; fidx_n = fidx_q; foff_n = foff_q;
		acc_n = acc_q; nul_n = nul_q; stop_n = stop_q; tm_n = tm_q;
		nl_n = nl_q; cl_n = cl_q; br_n = br_q;
		done = 1'b0; trl = 1'b0; val = '0; ft = 3'd0; v = '0;
		acc_base = '0; dig = '0; sh = '0; pos_inc = '0; br_dec = '0;
		err = cpiop_pkg::ERR_NONE;
		if (seg_q == cpiop_pkg::SEG_HEADER) begin
			tm_n = ((pos_q == 7'd0) ? 1'b1 : tm_q) &&
				(s_tdata == cpiop_pkg::trailer_byte(cfg.fmt, pos_q));
			acc_base = (foff_q == 4'd0) ? '0 : acc_q;
			nul_n = (foff_q == 4'd0) ? (s_tdata == 8'd0) : nul_q;
			stop_n = (foff_q == 4'd0) ? 1'b0 : stop_q;
			acc_n = acc_base;
			if (lay == cpiop_pkg::LAY_BIN) begin
				// Byte order within a word, and the high word first in a 4-byte field.
				sh = {1'b0, (cfg.fmt == cpiop_pkg::FMT_BIN_LE) ? foff_q[0] : ~foff_q[0], 3'b000};
				if (fl == 4'd4 && foff_q < 4'd2) sh = sh + 5'd16;
				acc_n = acc_base | (VW'(s_tdata) << sh);
			end else if (!stop_n) begin
				dig = cpiop_pkg::digit_of(s_tdata, lay == cpiop_pkg::LAY_HEX);
				if (!dig[4]) stop_n = 1'b1;
				else if (lay == cpiop_pkg::LAY_OCT) acc_n = {acc_base[VW-4:0], 3'b000} + VW'(dig[3:0]);
				else acc_n = {acc_base[VW-5:0], 4'b0000} + VW'(dig[3:0]);
			end
			done = (foff_q + 4'd1 == fl);
			v = (lay != cpiop_pkg::LAY_BIN && nul_n) ? '0 : acc_n;
			if (done) begin
				if (fidx_q == cpiop_pkg::mode_field(lay)) ft = cpiop_pkg::file_type_of(v);
				if (fidx_q == cpiop_pkg::namesize_field(lay)) nl_n = len_t'(v);
				if (fidx_q == cpiop_pkg::filesize_field(lay)) cl_n = len_t'(v);
				val = cpiop_pkg::quiet_field(lay, fidx_q) ? '0 : v;
			end
			pos_inc = pos_q + 7'd1;
			if (pos_inc >= cpiop_pkg::header_size(lay)) begin
				if (tm_n) begin
					trl = 1'b1;
					seg_n = cpiop_pkg::SEG_ARCHIVE;
				end else begin
					next_seg(cpiop_pkg::SEG_HEADER, lay, nl_n, cl_n, seg_n, br_n);
					pos_n = '0; fidx_n = '0; foff_n = '0; tm_n = 1'b1;
				end
			end else begin
				pos_n = pos_inc;
				if (done && fidx_q + 4'd1 < cpiop_pkg::field_count(lay)) begin
					fidx_n = fidx_q + 4'd1;
					foff_n = '0;
				end else begin
					foff_n = foff_q + 4'd1;
				end
			end
		end else if (seg_q != cpiop_pkg::SEG_ARCHIVE) begin
			br_dec = (br_q != '0) ? br_q - len_t'(1) : '0;
			br_n = br_dec;
			if (br_dec == '0) begin
				next_seg(seg_q, lay, nl_q, cl_q, seg_n, br_n);
				if (seg_n == cpiop_pkg::SEG_HEADER) begin
					pos_n = '0; fidx_n = '0; foff_n = '0; tm_n = 1'b1;
				end
			end
		end
		if (s_tlast) begin
			case (seg_n)
				cpiop_pkg::SEG_HEADER: err = (pos_n != 7'd0) ? cpiop_pkg::ERR_HEADER
					: cpiop_pkg::ERR_NONE;
				cpiop_pkg::SEG_NAME: err = cpiop_pkg::ERR_NAME;
				cpiop_pkg::SEG_NAMEPAD: err = (lay == cpiop_pkg::LAY_HEX) ? cpiop_pkg::ERR_NAMEPAD
					: cpiop_pkg::ERR_NONE;
				cpiop_pkg::SEG_CONTENTS: err = cpiop_pkg::ERR_CONTENTS;
				cpiop_pkg::SEG_CONTPAD: err = (lay == cpiop_pkg::LAY_HEX) ? cpiop_pkg::ERR_CONTPAD
					: cpiop_pkg::ERR_NONE;
				default: err = cpiop_pkg::ERR_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= cpiop_pkg::SEG_HEADER;
			pos_q <= '0; fidx_q <= '0; foff_q <= '0;
			acc_q <= '0; nul_q <= 1'b0; stop_q <= 1'b0; tm_q <= 1'b1;
			nl_q <= '0; cl_q <= '0; br_q <= '0;
		end else if (cfg.restart) begin
			seg_q <= cpiop_pkg::SEG_HEADER;
			pos_q <= '0; fidx_q <= '0; foff_q <= '0;
			acc_q <= '0; nul_q <= 1'b0; stop_q <= 1'b0; tm_q <= 1'b1;
			nl_q <= '0; cl_q <= '0; br_q <= '0;
		end else if (take) begin
			seg_q <= seg_n;
			pos_q <= pos_n; fidx_q <= fidx_n; foff_q <= foff_n;
			acc_q <= acc_n; nul_q <= nul_n; stop_q <= stop_n; tm_q <= tm_n;
			nl_q <= nl_n; cl_q <= cl_n; br_q <= br_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (take) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tuser <= seg_q;
			m_tdata <= {3'b000, err, trl, ft, val, done,
				(seg_q == cpiop_pkg::SEG_HEADER) ? fidx_q : 4'd0};
		end
	end
endmodule

// ----- src/cpiop_checker.sv -----
// Port-level assertions for the cpio stream parser, bound to its top level.
module cpiop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);
	a_value_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[37:5] == '0 && m_tdata[40:38] == 3'd0)
		else $error("field value or file type without a completed field");

	a_trailer_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[41] |-> m_tdata[4] && m_tuser == 3'd0)
		else $error("trailer flag outside a completed header field");

	a_index_only_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != 3'd0 |-> m_tdata[3:0] == 4'd0 && !m_tdata[4])
		else $error("field index reported outside the header");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
endmodule

bind cpio_archive_stream_parser_unit cpiop_checker u_cpiop_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
